// ----- rtl/core/mrrp_pkg.sv -----
// Package: shared types, codes and helpers for the mirror rank reorder block.
`default_nettype none
package mrrp_pkg;

  localparam int MaxSourcesDef  = 16;
  localparam int MinFinishedDef = 3;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;

  localparam logic [1:0] RO_NONE = 2'd0;
  localparam logic [1:0] RO_UP   = 2'd1;
  localparam logic [1:0] RO_DOWN = 2'd2;
  localparam logic [1:0] RO_END  = 2'd3;

  localparam logic [1:0] CFG_IN_USE  = 2'd0;
  localparam logic [1:0] CFG_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_WAIT    = 2'd2;
  localparam logic [1:0] CFG_FACTOR  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_CALC, ST_WB, ST_RDN, ST_MULX, ST_MULY, ST_DEC, ST_FIN
  } state_t;

  typedef enum logic [1:0] {PLAN_NONE, PLAN_END, PLAN_CMP} plan_t;

  typedef struct packed {
    logic [31:0] succ;
    logic [31:0] fail;
    logic [7:0]  run;
    logic [7:0]  peak;
    logic [15:0] rcnt;
    logic [31:0] rwait;
    logic [31:0] dline;
  } stat_t;

  typedef struct packed {
    logic accept;
    logic rd_self;
    logic rd_nb;
    logic calc;
    logic wb;
    logic mul_x;
    logic mul_y;
    logic dec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic bad_id;
    logic need_cmp;
    logic out_busy;
  } status_t;

  function automatic logic rank_known(input logic [31:0] succ, input logic [31:0] fail,
                                      input logic [7:0] min_fin);
    logic [32:0] total;
    total = {1'b0, succ} + {1'b0, fail};
    return total >= {25'd0, min_fin};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mrrp_ctrl.sv -----
// Controller: sequences read, update, writeback, ratio compare and result load.
`default_nettype none
module mrrp_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  mrrp_pkg::status_t   status,
  output mrrp_pkg::cmd_t      cmd
);

  mrrp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrrp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrrp_pkg::ST_IDLE: if (in_valid) state_nxt = mrrp_pkg::ST_RD;
      mrrp_pkg::ST_RD: begin
        state_nxt = status.bad_id ? mrrp_pkg::ST_FIN : mrrp_pkg::ST_CALC;
      end
      mrrp_pkg::ST_CALC: state_nxt = mrrp_pkg::ST_WB;
      mrrp_pkg::ST_WB: begin
        state_nxt = status.need_cmp ? mrrp_pkg::ST_RDN : mrrp_pkg::ST_DEC;
      end
      mrrp_pkg::ST_RDN: state_nxt = mrrp_pkg::ST_MULX;
      mrrp_pkg::ST_MULX: state_nxt = mrrp_pkg::ST_MULY;
      mrrp_pkg::ST_MULY: state_nxt = mrrp_pkg::ST_DEC;
      mrrp_pkg::ST_DEC: state_nxt = mrrp_pkg::ST_FIN;
      mrrp_pkg::ST_FIN: if (!status.out_busy) state_nxt = mrrp_pkg::ST_IDLE;
      default: state_nxt = mrrp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      mrrp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      mrrp_pkg::ST_RD: cmd.rd_self = 1'b1;
      mrrp_pkg::ST_CALC: cmd.calc = 1'b1;
      mrrp_pkg::ST_WB: cmd.wb = 1'b1;
      mrrp_pkg::ST_RDN: cmd.rd_nb = 1'b1;
      mrrp_pkg::ST_MULX: cmd.mul_x = 1'b1;
      mrrp_pkg::ST_MULY: cmd.mul_y = 1'b1;
      mrrp_pkg::ST_DEC: cmd.dec = 1'b1;
      mrrp_pkg::ST_FIN: cmd.load_out = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/mrrp_dpath.sv -----
// Datapath: config registers, per-source counter memory, order table, result register.
`default_nettype none
module mrrp_dpath #(
  parameter int MAX_SOURCES  = mrrp_pkg::MaxSourcesDef,
  parameter int MIN_FINISHED = mrrp_pkg::MinFinishedDef
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_valid,
  input  wire  [1:0]         cfg_index,
  input  wire  [15:0]        cfg_data,
  input  wire  [1:0]         in_operation,
  input  wire  [3:0]         in_source_id,
  input  wire                in_success,
  input  wire                in_serious,
  input  wire  [31:0]        in_now_time,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [3:0]         out_position,
  output logic [1:0]         out_reorder,
  output logic               out_limit_reached,
  output logic               out_must_wait,
  output logic [7:0]         out_running_count,
  output logic               out_rank_known,
  input  mrrp_pkg::cmd_t     cmd,
  output mrrp_pkg::status_t  status
);

  localparam int SW = $clog2(MAX_SOURCES);
  localparam int NW = SW + 1;
  localparam logic [7:0] MinFin = 8'(MIN_FINISHED);

  // configuration
  logic [4:0]        in_use_r;
  logic signed [8:0] limit_r;
  logic [15:0]       init_wait_r;
  logic [4:0]        factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= 5'd16;
      limit_r     <= -9'sd1;
      init_wait_r <= 16'd1;
      factor_r    <= 5'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        mrrp_pkg::CFG_IN_USE: in_use_r    <= cfg_data[4:0];
        mrrp_pkg::CFG_LIMIT:  limit_r     <= $signed(cfg_data[8:0]);
        mrrp_pkg::CFG_WAIT:   init_wait_r <= cfg_data;
        mrrp_pkg::CFG_FACTOR: factor_r    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_act;
  always_comb begin
    if (in_use_r == 5'd0) begin
      n_act = NW'(1);
    end else if (32'(in_use_r) > 32'(MAX_SOURCES)) begin
      n_act = NW'(MAX_SOURCES);
    end else begin
      n_act = NW'(in_use_r);
    end
  end

  // captured transaction
  logic [1:0]    op_r;
  logic [SW-1:0] s_r;
  logic          ok_r, ser_r, bad_r;
  logic [31:0]   now_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_operation;
      s_r   <= SW'(in_source_id);
      ok_r  <= in_success;
      ser_r <= in_serious;
      now_r <= in_now_time;
      bad_r <= 32'(in_source_id) >= 32'(MAX_SOURCES);
    end
  end

  // counter memory; vld clear means reset value, fresh means wait = initial_wait
  mrrp_pkg::stat_t mem [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] vld_r, fresh_r;
  mrrp_pkg::stat_t rd_r, rd_eff, cur_r, wb_stat;
  logic rd_vld_r, rd_fresh_r;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] nb_src_r;

  assign rd_addr = cmd.rd_nb ? nb_src_r : s_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_self || cmd.rd_nb) begin
      rd_r       <= mem[rd_addr];
      rd_vld_r   <= vld_r[rd_addr];
      rd_fresh_r <= fresh_r[rd_addr];
    end
    if (cmd.wb) begin
      mem[s_r] <= wb_stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      fresh_r <= '1;
    end else begin
      if (cfg_valid && cfg_index == mrrp_pkg::CFG_WAIT) begin
        fresh_r <= '1;
      end
      if (cmd.wb) begin
        vld_r[s_r]   <= 1'b1;
        fresh_r[s_r] <= 1'b0;
      end
    end
  end

  always_comb begin
    rd_eff = rd_vld_r ? rd_r : '0;
    rd_eff.rwait = rd_fresh_r ? 32'(init_wait_r) : rd_r.rwait;
  end

  // shared multiplier, registered
  logic [63:0] mul_r, x_r;
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = rd_eff.rwait;
    mul_b = 32'(factor_r);
    if (cmd.mul_x) begin
      mul_a = cur_r.succ;
      mul_b = rd_eff.fail;
    end else if (cmd.mul_y) begin
      mul_a = rd_eff.succ;
      mul_b = cur_r.fail;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc || cmd.mul_x || cmd.mul_y) begin
      mul_r <= mul_a * mul_b;
    end
    if (cmd.mul_y) begin
      x_r <= mul_r;
    end
  end

  // counter update
  mrrp_pkg::stat_t calc_stat;
  logic calc_trig, trig_r;
  logic [7:0] run_inc;
  always_comb begin
    calc_stat = rd_eff;
    calc_trig = 1'b0;
    run_inc = (rd_eff.run == 8'hFF) ? rd_eff.run : rd_eff.run + 8'd1;
    if (op_r == mrrp_pkg::OP_START) begin
      calc_stat.run = run_inc;
      if (rd_eff.peak < run_inc) calc_stat.peak = run_inc;
    end else if (op_r == mrrp_pkg::OP_FINISH) begin
      if (rd_eff.run != 8'd0) calc_stat.run = rd_eff.run - 8'd1;
      if (ok_r) begin
        if (rd_eff.succ != '1) calc_stat.succ = rd_eff.succ + 32'd1;
      end else begin
        if (rd_eff.fail != '1) calc_stat.fail = rd_eff.fail + 32'd1;
        calc_trig = (calc_stat.fail == 32'd1) || (rd_eff.dline < now_r);
        if (calc_trig && rd_eff.rcnt != 16'hFFFF) calc_stat.rcnt = rd_eff.rcnt + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      cur_r  <= calc_stat;
      trig_r <= calc_trig;
    end else if (cmd.wb) begin
      cur_r <= wb_stat;
    end
  end

  // backoff: saturate product and deadline
  logic [31:0] w_sat;
  logic [32:0] dsum;
  always_comb begin
    w_sat = (mul_r[63:32] != 32'd0) ? '1 : mul_r[31:0];
    dsum = {1'b0, now_r} + {1'b0, w_sat};
    wb_stat = cur_r;
    if (trig_r) begin
      wb_stat.rwait = w_sat;
      wb_stat.dline = dsum[32] ? '1 : dsum[31:0];
    end
  end

  // order table and inverse map
  logic [SW-1:0] order_r [MAX_SOURCES];
  logic [SW-1:0] place_r [MAX_SOURCES];
  logic [SW-1:0] p_r, q_r, q_nxt;
  mrrp_pkg::plan_t plan_r, plan_nxt;
  logic [NW-1:0] pe;

  always_comb begin
    pe = NW'(p_r);
    plan_nxt = mrrp_pkg::PLAN_NONE;
    q_nxt = p_r;
    if (op_r == mrrp_pkg::OP_FINISH && n_act != NW'(1) && pe < n_act
        && !(!ok_r && pe + NW'(1) == n_act) && !(ok_r && p_r == '0)) begin
      if (ser_r && wb_stat.succ == 32'd0) begin
        plan_nxt = mrrp_pkg::PLAN_END;
        q_nxt = SW'(n_act - NW'(1));
      end else if (mrrp_pkg::rank_known(wb_stat.succ, wb_stat.fail, MinFin)) begin
        plan_nxt = mrrp_pkg::PLAN_CMP;
        q_nxt = ok_r ? p_r - SW'(1) : p_r + SW'(1);
      end
    end
  end

  logic move;
  logic rk_nb;
  assign rk_nb = mrrp_pkg::rank_known(rd_eff.succ, rd_eff.fail, MinFin);
  always_comb begin
    move = 1'b0;
    if (plan_r == mrrp_pkg::PLAN_END) begin
      move = 1'b1;
    end else if (plan_r == mrrp_pkg::PLAN_CMP) begin
      // x_r = s_self*f_nb, mul_r = s_nb*f_self
      move = !rk_nb || (ok_r ? (mul_r < x_r) : (x_r < mul_r));
    end
  end

  logic [SW-1:0] res_pos_r;
  logic [1:0]    res_ro_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SOURCES; i++) begin
        order_r[i] <= SW'(i);
        place_r[i] <= SW'(i);
      end
    end else if (cmd.dec && move) begin
      order_r[p_r]      <= nb_src_r;
      order_r[q_r]      <= s_r;
      place_r[s_r]      <= q_r;
      place_r[nb_src_r] <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_self) begin
      p_r <= place_r[s_r];
    end
    if (cmd.wb) begin
      plan_r   <= plan_nxt;
      q_r      <= q_nxt;
      nb_src_r <= order_r[q_nxt];
    end
    if (cmd.dec) begin
      res_pos_r <= move ? q_r : p_r;
      if (!move) begin
        res_ro_r <= mrrp_pkg::RO_NONE;
      end else if (plan_r == mrrp_pkg::PLAN_END) begin
        res_ro_r <= mrrp_pkg::RO_END;
      end else begin
        res_ro_r <= ok_r ? mrrp_pkg::RO_UP : mrrp_pkg::RO_DOWN;
      end
    end
  end

  // result register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (bad_r) begin
        out_position      <= '0;
        out_reorder       <= mrrp_pkg::RO_NONE;
        out_limit_reached <= 1'b0;
        out_must_wait     <= 1'b0;
        out_running_count <= '0;
        out_rank_known    <= 1'b0;
      end else begin
        out_position      <= 4'(res_pos_r);
        out_reorder       <= res_ro_r;
        out_limit_reached <= (limit_r != -9'sd1)
                             && ($signed({2'b00, cur_r.run}) >= 10'(limit_r));
        out_must_wait     <= (cur_r.rcnt != 16'd0) && (cur_r.dline > now_r);
        out_running_count <= cur_r.run;
        out_rank_known    <= mrrp_pkg::rank_known(cur_r.succ, cur_r.fail, MinFin);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign status.bad_id   = bad_r;
  assign status.need_cmp = (plan_nxt == mrrp_pkg::PLAN_CMP);
  assign status.out_busy = out_valid_r && !out_ready;

`ifndef SYNTH
  a_order_inverse: assert property (@(posedge clk) disable iff (!rst_n)
    place_r[order_r[0]] == '0)
    else $error("order table and place map disagree");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result overwritten while pending");
  a_wb_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |=> vld_r[$past(s_r)])
    else $error("written entry not marked valid");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/mirror_rank_reorder_policy.sv -----
// Per item: read, update, writeback, then neighbour read and two multiplies when a ratio
// compare is needed, then decision and result load. No new item is taken meanwhile, as
// one memory read port and a shared 32x32 multiplier serve backoff and both cross products.
// A finished result may wait at the output while the next item is taken.
// Reset (rst_n, synchronous): config to defaults, identity order, counters read as zero.
// No clearing pass: per-source valid bits stand in for the counter reset.
`default_nettype none
module mirror_rank_reorder_policy #(
  parameter int MAX_SOURCES  = mrrp_pkg::MaxSourcesDef,
  parameter int MIN_FINISHED = mrrp_pkg::MinFinishedDef
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [15:0]  cfg_data,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire  [1:0]   in_operation,
  input  wire  [3:0]   in_source_id,
  input  wire          in_success,
  input  wire          in_serious,
  input  wire  [31:0]  in_now_time,
  output logic         out_valid,
  input  wire          out_ready,
  output logic [3:0]   out_position,
  output logic [1:0]   out_reorder,
  output logic         out_limit_reached,
  output logic         out_must_wait,
  output logic [7:0]   out_running_count,
  output logic         out_rank_known
);

  mrrp_pkg::cmd_t    cmd;
  mrrp_pkg::status_t status;

  assign cfg_ready = 1'b1;

  mrrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mrrp_dpath #(
    .MAX_SOURCES  (MAX_SOURCES),
    .MIN_FINISHED (MIN_FINISHED)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_operation      (in_operation),
    .in_source_id      (in_source_id),
    .in_success        (in_success),
    .in_serious        (in_serious),
    .in_now_time       (in_now_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_position      (out_position),
    .out_reorder       (out_reorder),
    .out_limit_reached (out_limit_reached),
    .out_must_wait     (out_must_wait),
    .out_running_count (out_running_count),
    .out_rank_known    (out_rank_known),
    .cmd               (cmd),
    .status            (status)
  );

endmodule
`default_nettype wire

// ----- tb/sv/mirror_rank_reorder_policy_test.sv -----
// Self-checking testbench for mirror_rank_reorder_policy: directed table, then random phases.
`timescale 1ns / 1ps
module mirror_rank_reorder_policy_test;

  localparam logic [1:0] OP_START = mrrp_pkg::OP_START;
  localparam logic [1:0] OP_FINISH = mrrp_pkg::OP_FINISH;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_QUERY_ALT = 2'd3;
  localparam logic [1:0] RO_NONE = mrrp_pkg::RO_NONE;
  localparam logic [1:0] RO_UP = mrrp_pkg::RO_UP;
  localparam logic [1:0] RO_DOWN = mrrp_pkg::RO_DOWN;
  localparam logic [1:0] RO_END = mrrp_pkg::RO_END;
  localparam logic [1:0] CFG_IN_USE = mrrp_pkg::CFG_IN_USE;
  localparam logic [1:0] CFG_LIMIT = mrrp_pkg::CFG_LIMIT;
  localparam logic [1:0] CFG_WAIT = mrrp_pkg::CFG_WAIT;
  localparam logic [1:0] CFG_FACTOR = mrrp_pkg::CFG_FACTOR;
  localparam int NSRC = 16;
  localparam int MIN_DONE = 3;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE = 12;

  typedef struct {
    logic [3:0] position;
    logic [1:0] reorder;
    logic       limit_hit;
    logic       wait_hit;
    logic [7:0] running;
    logic       known;
  } status_rec_t;

  typedef struct {
    logic [1:0]  op;
    logic [3:0]  src;
    logic        ok;
    logic        serious;
    logic [31:0] stamp;
    logic        typed;
    status_rec_t want;
  } event_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = 2'd0;
  logic [3:0] in_source_id = 4'd0;
  logic in_success = 1'b0;
  logic in_serious = 1'b0;
  logic [31:0] in_now_time = 32'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_position;
  logic [1:0] out_reorder;
  logic out_limit_reached;
  logic out_must_wait;
  logic [7:0] out_running_count;
  logic out_rank_known;

  mirror_rank_reorder_policy dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's configuration and per-source statistics
  int unsigned in_use_reg;
  int          limit_reg;
  bit [31:0]   factor_reg;
  bit [3:0]    order_of[NSRC];
  bit [3:0]    place_of[NSRC];
  bit [31:0]   wins[NSRC];
  bit [31:0]   losses[NSRC];
  bit [7:0]    busy[NSRC];
  bit [15:0]   retries[NSRC];
  bit [31:0]   backoff[NSRC];
  bit [31:0]   deadline[NSRC];

  status_rec_t pending_status[$];
  int errors = 0;
  bit calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  logic [31:0] clock_now = 32'd0;

  task automatic report(input string msg);
    errors++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  function automatic bit ranked(input int s);
    return ({1'b0, wins[s]} + {1'b0, losses[s]}) >= MIN_DONE;
  endfunction

  // success ratio of a strictly below that of b, by cross products
  function automatic bit ratio_below(input int a, input int b);
    return ({32'd0, wins[a]} * {32'd0, losses[b]}) < ({32'd0, wins[b]} * {32'd0, losses[a]});
  endfunction

  function automatic void swap_places(input int p, input int q);
    bit [3:0] a, b;
    a = order_of[p];
    b = order_of[q];
    order_of[p] = b;
    order_of[q] = a;
    place_of[a] = q[3:0];
    place_of[b] = p[3:0];
  endfunction

  function automatic logic [1:0] rerank(input int s, input bit ok, input bit serious);
    int n, p, nb;
    n = (in_use_reg < 1) ? 1 : (in_use_reg > NSRC) ? NSRC : in_use_reg;
    p = place_of[s];
    if (n == 1 || p >= n) return RO_NONE;
    if (!ok && p + 1 == n) return RO_NONE;
    if (ok && p == 0) return RO_NONE;
    if (serious && wins[s] == 0) begin
      swap_places(p, n - 1);
      return RO_END;
    end
    if (!ranked(s)) return RO_NONE;
    if (!ok) begin
      nb = order_of[p + 1];
      if (!ranked(nb) || ratio_below(s, nb)) begin
        swap_places(p, p + 1);
        return RO_DOWN;
      end
    end else begin
      nb = order_of[p - 1];
      if (!ranked(nb) || ratio_below(nb, s)) begin
        swap_places(p, p - 1);
        return RO_UP;
      end
    end
    return RO_NONE;
  endfunction

  function automatic status_rec_t apply_event(input logic [1:0] op, input int s, input bit ok,
                                              input bit serious, input bit [31:0] now);
    status_rec_t r;
    bit late;
    bit [63:0] w, d;
    r.reorder = RO_NONE;
    if (op == OP_START) begin
      if (busy[s] != 8'hFF) busy[s]++;
    end else if (op == OP_FINISH) begin
      if (busy[s] != 0) busy[s]--;
      if (ok) begin
        if (wins[s] != 32'hFFFF_FFFF) wins[s]++;
      end else begin
        late = deadline[s] < now;
        if (losses[s] != 32'hFFFF_FFFF) losses[s]++;
        if (losses[s] == 1 || late) begin
          if (retries[s] != 16'hFFFF) retries[s]++;
          w = {32'd0, backoff[s]} * {32'd0, factor_reg};
          if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
          backoff[s] = w[31:0];
          d = {32'd0, now} + w;
          if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
          deadline[s] = d[31:0];
        end
      end
      r.reorder = rerank(s, ok, serious);
    end
    r.position = place_of[s];
    r.limit_hit = (limit_reg != -1) && (int'(busy[s]) >= limit_reg);
    r.wait_hit = (retries[s] != 0) && (deadline[s] > now);
    r.running = busy[s];
    r.known = ranked(s);
    return r;
  endfunction

  task automatic send_event(input event_row_t row);
    status_rec_t v;
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= row.op;
    in_source_id <= row.src;
    in_success <= row.ok;
    in_serious <= row.serious;
    in_now_time <= row.stamp;
    do @(posedge clk); while (!in_ready);
    v = apply_event(row.op, row.src, row.ok, row.serious, row.stamp);
    pending_status.push_back(row.typed ? row.want : v);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IN_USE: in_use_reg = data[4:0];
      CFG_LIMIT:  limit_reg = $signed(data[8:0]);
      CFG_WAIT: begin
        for (int i = 0; i < NSRC; i++) backoff[i] = data;
      end
      default:    factor_reg = data[4:0];
    endcase
  endtask

  // registers change only with nothing in flight; bits above the in_use, limit and factor fields carry junk
  task automatic set_policy(input logic [4:0] in_use, input logic [8:0] limit,
                            input logic [15:0] init_wait, input logic [4:0] factor);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_IN_USE, {11'($urandom), in_use});
    write_reg(CFG_LIMIT, {7'($urandom), limit});
    write_reg(CFG_WAIT, init_wait);
    write_reg(CFG_FACTOR, {11'($urandom), factor});
    cfg_valid <= 1'b0;
  endtask

  function automatic event_row_t random_event(input int span);
    event_row_t r;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 7) r.op = OP_START;
    else if (pick < 16) r.op = OP_FINISH;
    else if (pick < 19) r.op = OP_QUERY;
    else r.op = OP_QUERY_ALT;
    r.src = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, span));
    r.ok = ($urandom_range(0, 9) < 6);
    r.serious = $urandom_range(0, 1);
    case ($urandom_range(0, 15))
      0: r.stamp = $urandom;
      1: r.stamp = 32'hFFFF_FFFF - $urandom_range(0, 40);
      default: begin
        clock_now = clock_now + $urandom_range(0, 20);
        r.stamp = clock_now;
      end
    endcase
    r.typed = 1'b0;
    return r;
  endfunction

  task automatic random_phase(input int count, input int span);
    for (int k = 0; k < count; k++) send_event(random_event(span));
  endtask

  function automatic status_rec_t st(input int pos, input int ro, input bit lim, input bit wt,
                                     input int run, input bit kn);
    status_rec_t r;
    r.position = 4'(pos);
    r.reorder = 2'(ro);
    r.limit_hit = lim;
    r.wait_hit = wt;
    r.running = 8'(run);
    r.known = kn;
    return r;
  endfunction

  function automatic event_row_t row(input logic [1:0] op, input int src, input bit ok,
                                     input bit ser, input logic [31:0] stamp,
                                     input bit typed, input status_rec_t want);
    event_row_t r;
    r.op = op;
    r.src = 4'(src);
    r.ok = ok;
    r.serious = ser;
    r.stamp = stamp;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    status_rec_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        report("result transaction with nothing expected");
      end else begin
        e = pending_status.pop_front();
        if (out_position !== e.position)
          report($sformatf("position %0d, expected %0d", out_position, e.position));
        if (out_reorder !== e.reorder)
          report($sformatf("reorder %0d, expected %0d", out_reorder, e.reorder));
        if (out_limit_reached !== e.limit_hit)
          report($sformatf("limit_reached %b, expected %b", out_limit_reached, e.limit_hit));
        if (out_must_wait !== e.wait_hit)
          report($sformatf("must_wait %b, expected %b", out_must_wait, e.wait_hit));
        if (out_running_count !== e.running)
          report($sformatf("running_count %0d, expected %0d", out_running_count, e.running));
        if (out_rank_known !== e.known)
          report($sformatf("rank_known %b, expected %b", out_rank_known, e.known));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("mirror_rank_reorder_policy regression: fail");
      $finish;
    end
  end

  event_row_t plan[$];

  initial begin
    in_use_reg = 16;
    limit_reg = -1;
    factor_reg = 2;
    for (int i = 0; i < NSRC; i++) begin
      order_of[i] = 4'(i);
      place_of[i] = 4'(i);
      wins[i] = 0;
      losses[i] = 0;
      busy[i] = 0;
      retries[i] = 0;
      backoff[i] = 1;
      deadline[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, serious first failure, rank moves, odd codes, extreme fields
    plan.push_back(row(OP_QUERY, 5, 0, 0, 32'd0, 1, st(5, RO_NONE, 0, 0, 0, 0)));
    plan.push_back(row(OP_START, 0, 0, 0, 32'd10, 1, st(0, RO_NONE, 0, 0, 1, 0)));
    plan.push_back(row(OP_FINISH, 0, 0, 1, 32'd100, 1, st(15, RO_END, 0, 1, 0, 0)));
    plan.push_back(row(OP_QUERY_ALT, 15, 1, 1, 32'hFFFF_FFFF, 1, st(0, RO_NONE, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 3, 1, 0, 32'd200, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 3, 1, 0, 32'd201, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 3, 1, 1, 32'd202, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 3, 1, 0, 32'd203, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 4, 0, 0, 32'd300, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 4, 0, 0, 32'd400, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 4, 0, 0, 32'd500, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 4, 0, 1, 32'd501, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 15, 0, 0, 32'hFFFF_FFF0, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_FINISH, 15, 0, 0, 32'hFFFF_FFFF, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_START, 15, 1, 1, 32'hFFFF_FFFF, 0, st(0, 0, 0, 0, 0, 0)));
    plan.push_back(row(OP_QUERY, 0, 0, 0, 32'd101, 0, st(0, 0, 0, 0, 0, 0)));
    foreach (plan[i]) send_event(plan[i]);

    random_phase(170, 15);
    set_policy(5'd4, 9'd0, 16'd0, 5'd0);
    random_phase(170, 6);
    set_policy(5'd0, 9'h100, 16'hFFFF, 5'd16);
    random_phase(170, 3);
    set_policy(5'd31, 9'd255, 16'd7, 5'd31);
    // drive one source past its running-count ceiling
    for (int k = 0; k < 270; k++)
      send_event(row(OP_START, 9, 0, 0, clock_now, 0, st(0, 0, 0, 0, 0, 0)));
    random_phase(170, 15);
    set_policy(5'd8, 9'h1FF, 16'd1, 5'd3);
    calm = 1'b1;
    random_phase(170, 9);

    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_status.size() != 0) report("expected results left over");
    if (errors == 0)
      $display("mirror_rank_reorder_policy regression: pass");
    else
      $display("mirror_rank_reorder_policy regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mrrp_pkg.sv
rtl/core/mrrp_ctrl.sv
rtl/core/mrrp_dpath.sv
rtl/core/mirror_rank_reorder_policy.sv
tb/sv/mirror_rank_reorder_policy_test.sv
